FILE: rtl/core/srgr_pkg.sv
`timescale 1ns / 1ps

package srgr_pkg;

    // Default sizes handed to the top level parameters.
    localparam int unsigned WINDOW_DEF      = 32;
    localparam int unsigned HANDLE_BITS_DEF = 16;

    localparam logic [63:0] START_SEQ_RESET = 64'd1;
    localparam logic [15:0] GAP_CAP         = 16'hFFFE;

    // Request type codes of an input item.
    localparam logic [1:0] REQ_MSG       = 2'd0;
    localparam logic [1:0] REQ_HEARTBEAT = 2'd1;
    localparam logic [1:0] REQ_END       = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_MSG    = 2'd0;
    localparam logic [1:0] KIND_GAP    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_REL_IN,
        EMIT_REL_SLOT,
        EMIT_GAP,
        EMIT_STATUS
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      latch_sess;
        logic      flag_sess;
        logic      flag_end;
        logic      flag_stale;
        logic      flag_over;
        logic      park;
        logic      advance;
        logic      clear_head;
        logic      req_clear_chk;
        logic      scan_start;
        logic      scan_next;
        logic      nxt_from_seq;
        logic      nxt_from_scan;
        logic      req_eval;
        logic      req_issue;
        emit_sel_t emit;
    } srgr_cmd_t;

    typedef struct packed {
        logic type_bad;
        logic is_msg;
        logic is_end;
        logic sess_seen;
        logic sess_match;
        logic seq_lt;
        logic seq_eq;
        logic place_ok;
        logic place_free;
        logic head_valid;
        logic pend;
        logic out_free;
        logic scan_hit;
        logic scan_done;
        logic req_needed;
    } srgr_status_t;

endpackage

FILE: rtl/core/srgr_dp.sv
`timescale 1ns / 1ps

module srgr_dp
    import srgr_pkg::*;
#(
    parameter int unsigned WINDOW      = WINDOW_DEF,
    parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [63:0]            cfg_wr_data,
    input  logic [1:0]             req_type,
    input  logic [15:0]            session_hi,
    input  logic [63:0]            session_lo,
    input  logic [63:0]            seq_num,
    input  logic [HANDLE_BITS-1:0] payload_handle,
    input  logic                   packet_end,
    input  srgr_cmd_t              cmd,
    output srgr_status_t           st,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_kind,
    output logic [63:0]            out_seq,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic [15:0]            gap_count,
    output logic                   stale_flag,
    output logic                   session_error,
    output logic                   window_overflow,
    output logic                   session_ended,
    output logic                   last_result
);

    localparam int unsigned IW       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [IW:0]   WIN_W  = (IW + 1)'(WINDOW);
    localparam logic [IW-1:0] LAST_K = IW'(WINDOW - 1);
    localparam logic [63:0]   WIN64  = 64'(WINDOW);

    // Sequencing state.
    logic [63:0]       exp_reg;
    logic [IW-1:0]     head_reg;
    logic [WINDOW-1:0] valid_reg;
    logic              seen_reg;
    logic [15:0]       lat_hi_reg;
    logic [63:0]       lat_lo_reg;
    logic [63:0]       rq_first_reg;
    logic [63:0]       rq_last_reg;
    logic              f_stale_reg;
    logic              f_sess_reg;
    logic              f_over_reg;
    logic              f_end_reg;
    logic [IW-1:0]     k_reg;
    logic              need_reg;
    logic              out_valid_reg;

    // Item payload and working values.
    logic [1:0]             type_reg;
    logic [15:0]            shi_reg;
    logic [63:0]            slo_reg;
    logic [63:0]            seq_reg;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic                   pend_reg;
    logic [63:0]            d_reg;
    logic [63:0]            nxt_reg;
    logic [63:0]            gap_reg;
    logic [HANDLE_BITS-1:0] rd_q_reg;

    logic [1:0]             kind_reg;
    logic [63:0]            oseq_reg;
    logic [HANDLE_BITS-1:0] ohnd_reg;
    logic [15:0]            ogap_reg;
    logic                   olast_reg;
    logic                   ostale_reg;
    logic                   osess_reg;
    logic                   oover_reg;
    logic                   oend_reg;

    logic [HANDLE_BITS-1:0] handle_mem [WINDOW];

    logic [IW:0]   place_sum;
    logic [IW-1:0] place_idx;
    logic [IW:0]   scan_sum;
    logic [IW-1:0] scan_idx;
    logic [IW-1:0] head_next;
    logic [15:0]   count;
    logic          out_free;

    always_comb
    begin
        place_sum = {1'b0, head_reg} + {1'b0, d_reg[IW-1:0]};
        place_idx = (place_sum >= WIN_W) ? IW'(place_sum - WIN_W) : place_sum[IW-1:0];
        scan_sum  = {1'b0, head_reg} + {1'b0, k_reg};
        scan_idx  = (scan_sum >= WIN_W) ? IW'(scan_sum - WIN_W) : scan_sum[IW-1:0];
        head_next = (head_reg == LAST_K) ? '0 : head_reg + 1'b1;
        count     = (gap_reg < 64'(GAP_CAP)) ? gap_reg[15:0] : GAP_CAP;
        out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        st.type_bad   = (type_reg != REQ_MSG) && (type_reg != REQ_HEARTBEAT)
                        && (type_reg != REQ_END);
        st.is_msg     = (type_reg == REQ_MSG);
        st.is_end     = (type_reg == REQ_END);
        st.sess_seen  = seen_reg;
        st.sess_match = (shi_reg == lat_hi_reg) && (slo_reg == lat_lo_reg);
        st.seq_lt     = seq_reg < exp_reg;
        st.seq_eq     = seq_reg == exp_reg;
        st.place_ok   = d_reg < WIN64;
        st.place_free = !valid_reg[place_idx];
        st.head_valid = valid_reg[head_reg];
        st.pend       = pend_reg;
        st.out_free   = out_free;
        st.scan_hit   = valid_reg[scan_idx];
        st.scan_done  = (k_reg == LAST_K);
        st.req_needed = need_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= START_SEQ_RESET;
            head_reg      <= '0;
            valid_reg     <= '0;
            seen_reg      <= 1'b0;
            lat_hi_reg    <= '0;
            lat_lo_reg    <= '0;
            rq_first_reg  <= '0;
            rq_last_reg   <= '0;
            f_stale_reg   <= 1'b0;
            f_sess_reg    <= 1'b0;
            f_over_reg    <= 1'b0;
            f_end_reg     <= 1'b0;
            k_reg         <= '0;
            need_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                // Loads the expected sequence; clears window, session, requests.
                exp_reg      <= cfg_wr_data;
                head_reg     <= '0;
                valid_reg    <= '0;
                seen_reg     <= 1'b0;
                lat_hi_reg   <= '0;
                lat_lo_reg   <= '0;
                rq_first_reg <= '0;
                rq_last_reg  <= '0;
            end
            else
            begin
                if (cmd.latch_sess)
                begin
                    seen_reg   <= 1'b1;
                    lat_hi_reg <= shi_reg;
                    lat_lo_reg <= slo_reg;
                end
                if (cmd.park)
                begin
                    valid_reg[place_idx] <= 1'b1;
                end
                if (cmd.clear_head)
                begin
                    valid_reg[head_reg] <= 1'b0;
                end
                if (cmd.advance)
                begin
                    exp_reg  <= exp_reg + 64'd1;
                    head_reg <= head_next;
                end
                if (cmd.req_clear_chk && (rq_last_reg < exp_reg))
                begin
                    rq_first_reg <= '0;
                    rq_last_reg  <= '0;
                end
                if (cmd.req_issue)
                begin
                    rq_first_reg <= exp_reg;
                    rq_last_reg  <= exp_reg + 64'(count) - 64'd1;
                end
            end

            if (cmd.load)
            begin
                f_stale_reg <= 1'b0;
                f_sess_reg  <= 1'b0;
                f_over_reg  <= 1'b0;
                f_end_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.flag_stale) f_stale_reg <= 1'b1;
                if (cmd.flag_sess)  f_sess_reg  <= 1'b1;
                if (cmd.flag_over)  f_over_reg  <= 1'b1;
                if (cmd.flag_end)   f_end_reg   <= 1'b1;
            end

            if (cmd.scan_start)
            begin
                k_reg <= IW'(1);
            end
            else if (cmd.scan_next)
            begin
                k_reg <= k_reg + 1'b1;
            end

            if (cmd.req_eval)
            begin
                need_reg <= (nxt_reg > exp_reg)
                            && !((rq_first_reg == exp_reg)
                                 && (rq_last_reg >= nxt_reg - 64'd1));
            end

            if (cmd.emit != EMIT_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= req_type;
            shi_reg  <= session_hi;
            slo_reg  <= session_lo;
            seq_reg  <= seq_num;
            hnd_reg  <= payload_handle;
            pend_reg <= packet_end;
        end
        d_reg <= seq_reg - exp_reg;
        if (cmd.nxt_from_seq)
        begin
            nxt_reg <= seq_reg;
        end
        else if (cmd.nxt_from_scan)
        begin
            nxt_reg <= exp_reg + 64'(k_reg);
        end
        if (cmd.req_eval)
        begin
            gap_reg <= nxt_reg - exp_reg;
        end
        if (cmd.park)
        begin
            handle_mem[place_idx] <= hnd_reg;
        end
        rd_q_reg <= handle_mem[head_reg];

        if (cmd.emit != EMIT_NONE)
        begin
            ostale_reg <= f_stale_reg;
            osess_reg  <= f_sess_reg;
            oover_reg  <= f_over_reg;
            oend_reg   <= f_end_reg;
            case (cmd.emit)
                EMIT_REL_IN:
                begin
                    kind_reg  <= KIND_MSG;
                    oseq_reg  <= exp_reg;
                    ohnd_reg  <= hnd_reg;
                    ogap_reg  <= '0;
                    olast_reg <= 1'b0;
                end
                EMIT_REL_SLOT:
                begin
                    kind_reg  <= KIND_MSG;
                    oseq_reg  <= exp_reg;
                    ohnd_reg  <= rd_q_reg;
                    ogap_reg  <= '0;
                    olast_reg <= 1'b0;
                end
                EMIT_GAP:
                begin
                    kind_reg  <= KIND_GAP;
                    oseq_reg  <= exp_reg;
                    ohnd_reg  <= '0;
                    ogap_reg  <= count;
                    olast_reg <= 1'b0;
                end
                default:
                begin
                    kind_reg  <= KIND_STATUS;
                    oseq_reg  <= '0;
                    ohnd_reg  <= '0;
                    ogap_reg  <= '0;
                    olast_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = kind_reg;
    assign out_seq         = oseq_reg;
    assign out_handle      = ohnd_reg;
    assign gap_count       = ogap_reg;
    assign stale_flag      = ostale_reg;
    assign session_error   = osess_reg;
    assign window_overflow = oover_reg;
    assign session_ended   = oend_reg;
    assign last_result     = olast_reg;

endmodule

FILE: rtl/core/srgr_ctrl.sv
`timescale 1ns / 1ps

module srgr_ctrl
    import srgr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  srgr_status_t st,
    output srgr_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASSIFY,
        S_RELEASE,
        S_DRAIN_RD,
        S_DRAIN,
        S_PLACE,
        S_PEND,
        S_SCAN,
        S_REQ_A,
        S_REQ_B,
        S_STATUS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (st.type_bad)
                begin
                    state_next = S_STATUS;
                end
                else if (st.sess_seen && !st.sess_match)
                begin
                    cmd.flag_sess = 1'b1;
                    state_next    = S_STATUS;
                end
                else
                begin
                    cmd.latch_sess = !st.sess_seen;
                    if (!st.is_msg)
                    begin
                        cmd.flag_end     = st.is_end;
                        cmd.nxt_from_seq = 1'b1;
                        state_next       = S_REQ_A;
                    end
                    else if (st.seq_lt)
                    begin
                        cmd.flag_stale = 1'b1;
                        state_next     = S_PEND;
                    end
                    else if (st.seq_eq)
                    begin
                        state_next = S_RELEASE;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
            end
            S_RELEASE:
            begin
                if (st.out_free)
                begin
                    cmd.emit    = EMIT_REL_IN;
                    cmd.advance = 1'b1;
                    state_next  = S_DRAIN_RD;
                end
            end
            S_DRAIN_RD:
            begin
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (st.head_valid)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit       = EMIT_REL_SLOT;
                        cmd.clear_head = 1'b1;
                        cmd.advance    = 1'b1;
                        state_next     = S_DRAIN_RD;
                    end
                end
                else
                begin
                    cmd.req_clear_chk = 1'b1;
                    state_next        = S_PEND;
                end
            end
            S_PLACE:
            begin
                if (!st.place_ok)
                begin
                    cmd.flag_over = 1'b1;
                end
                else if (st.place_free)
                begin
                    cmd.park = 1'b1;
                end
                state_next = S_PEND;
            end
            S_PEND:
            begin
                if (st.pend)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_SCAN:
            begin
                if (st.scan_hit)
                begin
                    cmd.nxt_from_scan = 1'b1;
                    state_next        = S_REQ_A;
                end
                else if (st.scan_done)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_REQ_A:
            begin
                cmd.req_eval = 1'b1;
                state_next   = S_REQ_B;
            end
            S_REQ_B:
            begin
                if (!st.req_needed)
                begin
                    state_next = S_STATUS;
                end
                else if (st.out_free)
                begin
                    cmd.emit      = EMIT_GAP;
                    cmd.req_issue = 1'b1;
                    state_next    = S_STATUS;
                end
            end
            S_STATUS:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = EMIT_STATUS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/sequence_reorder_gap_request.sv
`timescale 1ns / 1ps

// Sequence reorder and gap request stage for a sequenced multicast feed. Each input item is a
// message, a heartbeat or an end-of-session event; the first item fixes the session and items
// from any other session are answered with a status result carrying session_error. A message at
// the expected sequence is released at once and is followed by any contiguous successors parked
// in a reorder window of WINDOW slots, each slot holding only the payload handle; earlier
// sequences are dropped as stale and sequences WINDOW or more ahead are dropped as overflow.
// On a heartbeat, an end event, or a message with packet_end set and a parked successor, a
// retransmit request for the missing range is issued, capped at 65534 sequences and suppressed
// when an earlier request already covers it. Every item ends with exactly one status result,
// marked by last_result. Items are handled one at a time: the input reopens on the edge that
// issues an item's status result. Each drained slot passes through a read state first
// because the handle memory has a registered read port, and packet_end adds a scan of the
// slot valid bits at one slot per cycle. Any cycle in which the output register is still
// held by the receiver stalls the item further. A write to start_sequence resets the
// expected sequence, the window, the session and the request range; the user must make it
// only while the block is idle, which the block itself does not enforce.
module sequence_reorder_gap_request
    import srgr_pkg::*;
#(
    parameter int unsigned WINDOW      = WINDOW_DEF,
    parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [63:0]            cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             req_type,
    input  logic [15:0]            session_hi,
    input  logic [63:0]            session_lo,
    input  logic [63:0]            seq_num,
    input  logic [HANDLE_BITS-1:0] payload_handle,
    input  logic                   packet_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_kind,
    output logic [63:0]            out_seq,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic [15:0]            gap_count,
    output logic                   stale_flag,
    output logic                   session_error,
    output logic                   window_overflow,
    output logic                   session_ended,
    output logic                   last_result
);

    srgr_cmd_t    cmd;
    srgr_status_t st;

    // The controller sequences each item; the datapath holds the window and the output register.
    srgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    srgr_dp #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req_type        (req_type),
        .session_hi      (session_hi),
        .session_lo      (session_lo),
        .seq_num         (seq_num),
        .payload_handle  (payload_handle),
        .packet_end      (packet_end),
        .cmd             (cmd),
        .st              (st),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_kind        (out_kind),
        .out_seq         (out_seq),
        .out_handle      (out_handle),
        .gap_count       (gap_count),
        .stale_flag      (stale_flag),
        .session_error   (session_error),
        .window_overflow (window_overflow),
        .session_ended   (session_ended),
        .last_result     (last_result)
    );

    // Only one item is in flight, so an accepted item closes the input until its status is out.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again while an item is in flight");

    // A status result is always the last result of its item, and nothing else is.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_kind == KIND_STATUS) == last_result))
        else $error("last_result does not match a status result");

    // A gap request asks for at least one and at most the capped number of sequences.
    a_gap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind == KIND_GAP)) |-> ((gap_count != 16'd0) && (gap_count <= GAP_CAP)))
        else $error("gap request count out of range");

    // The input reopens only once the status result has been placed in the output register.
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready ##1 in_ready) |-> (out_valid && (out_kind == KIND_STATUS)))
        else $error("input reopened without a status result");

endmodule
